// ===== hw/rtl/tvbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tvbt_pkg
// Shared types, constants and calendar tables for the calendar-to-tick
// converter.
// ----------------------------------------------------------------------------
package tvbt_pkg;

	localparam int unsigned YEAR_LOW       = 1858;
	localparam int unsigned YEAR_HIGH      = 9999;
	localparam int unsigned ORIGIN_YEAR    = 1601;
	localparam int unsigned EPOCH_DAYS     = 94187;
	localparam int unsigned RECIP_100      = 5243;   // 2^19 / 100, rounded up
	localparam int unsigned RECIP_SHIFT    = 19;
	localparam int unsigned CS_PER_HOUR    = 360000;
	localparam int unsigned CS_PER_MINUTE  = 6000;
	localparam int unsigned CS_PER_SECOND  = 100;
	localparam int unsigned TICKS_PER_CS   = 100000;
	// ticks per day = 864e9 = 52734375 * 2^14
	localparam int unsigned DAY_TICKS_ODD  = 52734375;
	localparam int unsigned DAY_TICKS_SHIFT = 14;

	localparam int unsigned DAYS_W = 22;
	localparam int unsigned CS_W   = 24;
	localparam int unsigned PROD_W = 26;

	// Input transaction, year in the lowest bits
	typedef struct packed {
		logic [15:0] hundredth;
		logic [15:0] second;
		logic [15:0] minute;
		logic [15:0] hour;
		logic [15:0] day;
		logic [15:0] month;
		logic [15:0] year;
	} in_t;

	typedef struct packed {
		logic              delta;
		logic              ok;
		logic [DAYS_W-1:0] days;
		logic [CS_W-1:0]   cs;
	} days_t;

	typedef struct packed {
		logic        delta;
		logic        ok;
		logic [63:0] ticks;
	} ticks_t;

	// Days in the year before the given month (1..12)
	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] r;
		case (month)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Length of the month in a common year
	function automatic logic [4:0] month_len(input logic [3:0] month);
		logic [4:0] r;
		case (month)
			4'd2:                       r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
			default:                    r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/time_vector_to_binary_time.sv =====
// Throughput: one transaction per cycle while m_tready is high; five register
// stages, each with its own valid bit, so bubbles close up while the output
// is stalled.
// Reset: arst_n clears all valid bits; the pipeline comes up empty and
// ready. Data registers are not reset.
// ----------------------------------------------------------------------------
// time_vector_to_binary_time
// Converts a calendar date and time, or a day delta, into a 64-bit count
// of 100 ns ticks with an invalid-field flag.
// ----------------------------------------------------------------------------
module time_vector_to_binary_time (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// year, month, day, hour, minute, second, hundredth (16 bits each)
	input  logic [111:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// binary_time
	output logic [63:0]   m_tdata,
	// status
	output logic [0:0]    m_tuser
);

	tvbt_pkg::in_t    in_data;
	logic             days_valid;
	logic             days_ready;
	tvbt_pkg::days_t  days_data;
	logic             ticks_valid;
	logic             ticks_ready;
	tvbt_pkg::ticks_t ticks_data;

	logic             valid_s5;
	logic [63:0]      time_s5;
	logic             status_s5;

	assign in_data = tvbt_pkg::in_t'(s_tdata);

	tvbt_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (in_data),
		.out_valid (days_valid),
		.out_ready (days_ready),
		.out_data  (days_data)
	);

	tvbt_ticks u_ticks (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (days_valid),
		.in_ready  (days_ready),
		.in_data   (days_data),
		.out_valid (ticks_valid),
		.out_ready (ticks_ready),
		.out_data  (ticks_data)
	);

	// output stage: negate deltas, zero invalid items
	assign ticks_ready = !valid_s5 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ticks_ready) begin
			valid_s5 <= ticks_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ticks_ready && ticks_valid) begin
			status_s5 <= !ticks_data.ok;
			if (!ticks_data.ok) begin
				time_s5 <= 64'd0;
			end else if (ticks_data.delta) begin
				time_s5 <= (~ticks_data.ticks) + 64'd1;
			end else begin
				time_s5 <= ticks_data.ticks;
			end
		end
	end

	assign m_tvalid   = valid_s5;
	assign m_tdata    = time_s5;
	assign m_tuser[0] = status_s5;

endmodule

// ===== hw/rtl/tvbt_days.sv =====
// ----------------------------------------------------------------------------
// tvbt_days
// Two-stage calendar front end: field checks, day-of-year, the day count
// since the epoch (or the day delta) and the centisecond time-of-day count.
// ----------------------------------------------------------------------------
module tvbt_days (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tvbt_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output tvbt_pkg::days_t  out_data
);

	// stage 1 comb
	logic                            delta_c;
	logic                            date_ok_c;
	logic                            time_ok_c;
	logic [13:0]                     yr14_c;
	logic [13:0]                     y_c;
	logic [3:0]                      mon_c;
	logic [21:0]                     base_c;
	logic [tvbt_pkg::CS_W-1:0]       cs_c;

	// stage 1 registers
	logic                            valid_s1;
	logic                            delta_s1;
	logic                            pre_ok_s1;
	logic [15:0]                     day_s1;
	logic [3:0]                      mon_s1;
	logic [1:0]                      yr_lo_s1;
	logic [13:0]                     yr_s1;
	logic [tvbt_pkg::PROD_W-1:0]     yr_prod_s1;
	logic [tvbt_pkg::PROD_W-1:0]     y_prod_s1;
	logic [21:0]                     base_s1;
	logic [tvbt_pkg::CS_W-1:0]       cs_s1;

	// stage 2 comb
	logic [6:0]                      yr_div_c;
	logic [6:0]                      y_div_c;
	logic                            cent_c;
	logic                            leap_c;
	logic                            len_ok_c;
	logic [21:0]                     total_c;
	logic [22:0]                     diff_c;
	logic                            ok_c;
	logic [tvbt_pkg::DAYS_W-1:0]     days_c;

	logic                            valid_s2;
	tvbt_pkg::days_t                 data_s2;
	logic                            ready_s1;
	logic                            ready_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// ---- stage 1: range checks, constant products, partial day sum
	always_comb begin
		delta_c   = (in_data.year == 16'd0) && (in_data.month == 16'd0);
		date_ok_c = (in_data.year >= 16'(tvbt_pkg::YEAR_LOW)) &&
			(in_data.year <= 16'(tvbt_pkg::YEAR_HIGH)) &&
			(in_data.month >= 16'd1) && (in_data.month <= 16'd12) &&
			(in_data.day != 16'd0);
		time_ok_c = (in_data.hour <= 16'd23) && (in_data.minute <= 16'd59) &&
			(in_data.second <= 16'd59) && (in_data.hundredth <= 16'd99);
		yr14_c = in_data.year[13:0];
		y_c    = yr14_c - 14'(tvbt_pkg::ORIGIN_YEAR);
		mon_c  = in_data.month[3:0];
		base_c = 22'(22'(y_c) * 22'd365) + 22'(y_c[13:2]) +
			22'(tvbt_pkg::days_before(mon_c)) + 22'(in_data.day[4:0]);
		cs_c = 24'(24'(in_data.hour[4:0]) * 24'(tvbt_pkg::CS_PER_HOUR)) +
			24'(24'(in_data.minute[5:0]) * 24'(tvbt_pkg::CS_PER_MINUTE)) +
			24'(24'(in_data.second[5:0]) * 24'(tvbt_pkg::CS_PER_SECOND)) +
			24'(in_data.hundredth[6:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			delta_s1   <= delta_c;
			pre_ok_s1  <= (delta_c || date_ok_c) && time_ok_c;
			day_s1     <= in_data.day;
			mon_s1     <= mon_c;
			yr_lo_s1   <= in_data.year[1:0];
			yr_s1      <= yr14_c;
			yr_prod_s1 <= tvbt_pkg::PROD_W'(yr14_c) * tvbt_pkg::PROD_W'(tvbt_pkg::RECIP_100);
			y_prod_s1  <= tvbt_pkg::PROD_W'(y_c) * tvbt_pkg::PROD_W'(tvbt_pkg::RECIP_100);
			base_s1    <= base_c;
			cs_s1      <= cs_c;
		end
	end

	// ---- stage 2: leap year, month length, century terms, epoch offset
	always_comb begin
		yr_div_c = yr_prod_s1[tvbt_pkg::RECIP_SHIFT +: 7];
		y_div_c  = y_prod_s1[tvbt_pkg::RECIP_SHIFT +: 7];
		cent_c   = (14'(yr_div_c) * 14'd100) == yr_s1;
		leap_c   = (yr_lo_s1 == 2'd0) && (!cent_c || (yr_div_c[1:0] == 2'd0));
		len_ok_c = day_s1 <= 16'(5'(tvbt_pkg::month_len(mon_s1) +
			5'((mon_s1 == 4'd2) && leap_c)));
		total_c  = base_s1 + 22'((mon_s1 > 4'd2) && leap_c) - 22'(y_div_c) +
			22'(y_div_c[6:2]);
		diff_c   = {1'b0, total_c} - 23'(tvbt_pkg::EPOCH_DAYS + 1);
		ok_c     = pre_ok_s1 && (delta_s1 || (len_ok_c && !diff_c[22]));
		days_c   = delta_s1 ? tvbt_pkg::DAYS_W'(day_s1) : diff_c[tvbt_pkg::DAYS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2.delta <= delta_s1;
			data_s2.ok    <= ok_c;
			data_s2.days  <= days_c;
			data_s2.cs    <= cs_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== hw/rtl/tvbt_ticks.sv =====
// ----------------------------------------------------------------------------
// tvbt_ticks
// Two-stage tick datapath: day and centisecond products, then the 64-bit
// sum ticks = days * 864e9 + cs * 1e5.
// ----------------------------------------------------------------------------
module tvbt_ticks (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tvbt_pkg::days_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output tvbt_pkg::ticks_t out_data
);

	localparam int unsigned DAY_PROD_W = tvbt_pkg::DAYS_W + 26;
	localparam int unsigned CS_PROD_W  = tvbt_pkg::CS_W + 17;

	logic                  valid_s3;
	logic                  delta_s3;
	logic                  ok_s3;
	logic [DAY_PROD_W-1:0] day_prod_s3;
	logic [CS_PROD_W-1:0]  cs_prod_s3;

	logic                  valid_s4;
	tvbt_pkg::ticks_t      data_s4;
	logic                  ready_s3;
	logic                  ready_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			delta_s3    <= in_data.delta;
			ok_s3       <= in_data.ok;
			day_prod_s3 <= DAY_PROD_W'(in_data.days) * DAY_PROD_W'(tvbt_pkg::DAY_TICKS_ODD);
			cs_prod_s3  <= CS_PROD_W'(in_data.cs) * CS_PROD_W'(tvbt_pkg::TICKS_PER_CS);
		end
		if (ready_s4 && valid_s3) begin
			data_s4.delta <= delta_s3;
			data_s4.ok    <= ok_s3;
			data_s4.ticks <= (64'(day_prod_s3) << tvbt_pkg::DAY_TICKS_SHIFT) +
				64'(cs_prod_s3);
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule
